// File: rtl/tpim_pkg.sv
package tpim_pkg;

  localparam int NUM_AXES_MAX = 4;
  localparam int LANE_W       = 16;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int STRIDE_W     = 32;
  localparam int FILL_W       = 32;
  localparam int OFFSET_W     = 50;

  typedef enum logic [1:0] {
    MODE_FILL   = 2'd0,
    MODE_MIRROR = 2'd1,
    MODE_FOLD   = 2'd2,
    MODE_CLAMP  = 2'd3
  } border_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAD_MODE   = 4'd0,
    REG_AXIS_SIZE  = 4'd1,
    REG_PAD_BEFORE = 4'd2,
    REG_STRIDE_0   = 4'd3,
    REG_STRIDE_1   = 4'd4,
    REG_STRIDE_2   = 4'd5,
    REG_STRIDE_3   = 4'd6,
    REG_FILL_VALUE = 4'd7
  } cfg_reg_t;

  // Axis 0 sits in the high lane of axis_size and pad_before; stride[0] is the low word.
  typedef struct packed {
    border_mode_t                              pad_mode;
    logic [NUM_AXES_MAX*LANE_W-1:0]            axis_size;
    logic [NUM_AXES_MAX*LANE_W-1:0]            pad_before;
    logic [NUM_AXES_MAX-1:0][STRIDE_W-1:0]     stride;
    logic [FILL_W-1:0]                         fill_value;
  } cfg_t;

endpackage

// File: rtl/tpim_cfg_regs.sv
module tpim_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [tpim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpim_pkg::CFG_DATA_W-1:0] cfg_data,
  output tpim_pkg::cfg_t                  cfg
);
  import tpim_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_mode   <= MODE_FILL;
      cfg.axis_size  <= '0;
      cfg.pad_before <= '0;
      cfg.stride[0]  <= '0;
      cfg.stride[1]  <= '0;
      cfg.stride[2]  <= '0;
      cfg.stride[3]  <= STRIDE_W'(1);
      cfg.fill_value <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAD_MODE:   cfg.pad_mode   <= border_mode_t'(cfg_data[1:0]);
        REG_AXIS_SIZE:  cfg.axis_size  <= cfg_data[NUM_AXES_MAX*LANE_W-1:0];
        REG_PAD_BEFORE: cfg.pad_before <= cfg_data[NUM_AXES_MAX*LANE_W-1:0];
        REG_STRIDE_0:   cfg.stride[0]  <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_1:   cfg.stride[1]  <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_2:   cfg.stride[2]  <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_3:   cfg.stride[3]  <= cfg_data[STRIDE_W-1:0];
        REG_FILL_VALUE: cfg.fill_value <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tpim_axis_map.sv
module tpim_axis_map #(
  parameter int COORD_WIDTH = 16
) (
  input  logic [COORD_WIDTH-1:0]  coord,
  input  logic [COORD_WIDTH-1:0]  size,
  input  logic [COORD_WIDTH-1:0]  pad,
  input  tpim_pkg::border_mode_t  mode,
  output logic [COORD_WIDTH-1:0]  src,
  output logic                    border
);
  import tpim_pkg::*;

  localparam int RW = COORD_WIDTH + 3;
  localparam logic signed [RW-1:0] ONE = RW'(1);
  localparam logic signed [RW-1:0] TWO = RW'(2);

  logic signed [RW-1:0] rel;
  logic signed [RW-1:0] n;
  logic signed [RW-1:0] n_last;
  logic signed [RW-1:0] s_raw;
  logic signed [RW-1:0] s_lim;
  logic                 lead;
  logic                 reflective;

  always_comb begin
    n          = $signed({3'b000, size});
    n_last     = n - ONE;
    rel        = $signed({3'b000, coord}) - $signed({{3{pad[COORD_WIDTH-1]}}, pad});
    lead       = rel[RW-1];
    border     = lead || (rel >= n);
    reflective = (mode == MODE_MIRROR) || (mode == MODE_FOLD);

    s_raw = '0;
    if (lead) begin
      case (mode)
        MODE_MIRROR: s_raw = -rel;
        MODE_FOLD:   s_raw = -rel - ONE;
        default:     s_raw = '0;
      endcase
    end else begin
      case (mode)
        MODE_MIRROR: s_raw = (n <<< 1) - TWO - rel;
        MODE_FOLD:   s_raw = (n <<< 1) - ONE - rel;
        MODE_CLAMP:  s_raw = n_last;
        default:     s_raw = '0;
      endcase
    end

    // single reflection only: clamp into the axis
    s_lim = s_raw;
    if (reflective && (s_lim > n_last)) begin
      s_lim = n_last;
    end
    if (s_lim[RW-1]) begin
      s_lim = '0;
    end

    src = border ? s_lim[COORD_WIDTH-1:0] : rel[COORD_WIDTH-1:0];
  end

endmodule

// File: rtl/tensor_pad_index_mapper.sv
// Pad index mapper for a tensor of up to four axes. Each transaction on the
// input channel carries one output-element coordinate; the block returns the
// source coordinates, the flat source offset (sum of coordinate times stride),
// the pad flag, and the fill constant when constant mode applies. One
// transaction is accepted per clock while in_ready is high; each result
// passes through the four-stage pipeline: input register, per-axis border
// mapping, stride multiply, offset sum into the output register. Each stage
// holds while the one after it is full and stalled. Configuration writes are
// always ready and take effect on the next cycle; write them only while no
// transaction is in flight.
module tensor_pad_index_mapper #(
  parameter int NUM_AXES    = 4,
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpim_pkg::CFG_DATA_W-1:0] cfg_data,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tpim_pkg::LANE_W-1:0]     out_coord_0,
  input  logic [tpim_pkg::LANE_W-1:0]     out_coord_1,
  input  logic [tpim_pkg::LANE_W-1:0]     out_coord_2,
  input  logic [tpim_pkg::LANE_W-1:0]     out_coord_3,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tpim_pkg::LANE_W-1:0]     src_coord_0,
  output logic [tpim_pkg::LANE_W-1:0]     src_coord_1,
  output logic [tpim_pkg::LANE_W-1:0]     src_coord_2,
  output logic [tpim_pkg::LANE_W-1:0]     src_coord_3,
  output logic [tpim_pkg::OFFSET_W-1:0]   src_offset,
  output logic                            is_pad,
  output logic                            use_constant,
  output logic [tpim_pkg::FILL_W-1:0]     fill_data
);
  import tpim_pkg::*;

  localparam int PROD_W = COORD_WIDTH + STRIDE_W;

  cfg_t cfg;

  logic [COORD_WIDTH-1:0] in_coord [NUM_AXES_MAX];

  logic                   v1, v2, v3;
  logic                   r1, r2, r3, r4;
  logic [COORD_WIDTH-1:0] s1_coord [NUM_AXES_MAX];
  logic [COORD_WIDTH-1:0] s2_src   [NUM_AXES_MAX];
  logic                   s2_pad;
  logic [COORD_WIDTH-1:0] s3_src   [NUM_AXES_MAX];
  logic [PROD_W-1:0]      s3_prod  [NUM_AXES_MAX];
  logic                   s3_pad;
  logic [COORD_WIDTH-1:0] s4_src   [NUM_AXES_MAX];

  logic [COORD_WIDTH-1:0] map_src    [NUM_AXES_MAX];
  logic [NUM_AXES_MAX-1:0] map_border;
  logic [OFFSET_W-1:0]    offset_next;
  logic                   use_const_next;

  tpim_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  assign in_coord[0] = out_coord_0[COORD_WIDTH-1:0];
  assign in_coord[1] = out_coord_1[COORD_WIDTH-1:0];
  assign in_coord[2] = out_coord_2[COORD_WIDTH-1:0];
  assign in_coord[3] = out_coord_3[COORD_WIDTH-1:0];

  // stage readies: a stage loads when empty or when its successor moves
  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  for (genvar a = 0; a < NUM_AXES_MAX; a++) begin : g_axis
    if (a < NUM_AXES) begin : g_used
      tpim_axis_map #(
        .COORD_WIDTH (COORD_WIDTH)
      ) u_map (
        .coord  (s1_coord[a]),
        .size   (cfg.axis_size[LANE_W*(NUM_AXES_MAX-1-a) +: COORD_WIDTH]),
        .pad    (cfg.pad_before[LANE_W*(NUM_AXES_MAX-1-a) +: COORD_WIDTH]),
        .mode   (cfg.pad_mode),
        .src    (map_src[a]),
        .border (map_border[a])
      );
    end else begin : g_unused
      assign map_src[a]    = '0;
      assign map_border[a] = 1'b0;
    end
  end

  always_comb begin
    offset_next = '0;
    for (int a = 0; a < NUM_AXES_MAX; a++) begin
      offset_next = offset_next + OFFSET_W'(s3_prod[a]);
    end
    use_const_next = s3_pad && (cfg.pad_mode == MODE_FILL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_coord <= in_coord;
    end
    if (r2 && v1) begin
      s2_src <= map_src;
      s2_pad <= |map_border;
    end
    if (r3 && v2) begin
      for (int a = 0; a < NUM_AXES_MAX; a++) begin
        s3_prod[a] <= PROD_W'(s2_src[a]) * PROD_W'(cfg.stride[a]);
      end
      s3_src <= s2_src;
      s3_pad <= s2_pad;
    end
    if (r4 && v3) begin
      s4_src       <= s3_src;
      src_offset   <= offset_next;
      is_pad       <= s3_pad;
      use_constant <= use_const_next;
      fill_data    <= use_const_next ? cfg.fill_value : '0;
    end
  end

  assign src_coord_0 = LANE_W'(s4_src[0]);
  assign src_coord_1 = LANE_W'(s4_src[1]);
  assign src_coord_2 = LANE_W'(s4_src[2]);
  assign src_coord_3 = LANE_W'(s4_src[3]);

  a_const_needs_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!use_constant || is_pad))
    else $error("use_constant without pad flag");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !use_constant) |-> (fill_data == '0))
    else $error("fill_data nonzero outside constant fill");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted transaction not held in input stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
